[design/bfir_pkg.sv]
// bfir_pkg: constants, register and action codes, and shared types for the
// block FIR filter. No dependencies; every other file in this folder imports it.

package bfir_pkg;

  localparam int MAX_TAPS    = 63;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 15;

  localparam int TAP_BITS   = $clog2(MAX_TAPS + 1);
  localparam int COEF_AW    = $clog2(MAX_TAPS);
  localparam int RING_AW    = $clog2(MAX_TAPS);
  localparam int RING_DEPTH = 2 ** RING_AW;

  // tap after spectral inversion spans -(2^15 - 1) .. 2^16
  localparam int H_BITS    = COEF_BITS + 2;
  localparam int PROD_BITS = H_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + TAP_BITS;

  localparam logic signed [H_BITS-1:0] H_ONE = H_BITS'(1 << COEF_FRAC);

  // configuration port
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_BITS     = TAP_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGHPASS  = 1'b1;

  localparam logic [TAP_BITS-1:0] TAP_COUNT_RST = TAP_BITS'(MAX_TAPS);

  // input item actions
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // one tap read, passed from the read stage into the MAC pipeline
  typedef struct packed {
    logic vld;
    logic centre;
    logic highpass;
    logic smp_vld;
  } mac_ctl_t;

endpackage

[design/bfir_if.sv]
// bfir_in_if / bfir_out_if: valid/ready channels of the block FIR filter.
// Depends on bfir_pkg for field widths.

interface bfir_in_if import bfir_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [TAP_BITS-1:0]           coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;
  logic                          block_end;

  modport source (output valid, action, sample_in, coef_index, coef_value, block_end,
                  input ready);
  modport sink   (input valid, action, sample_in, coef_index, coef_value, block_end,
                  output ready);
endinterface

interface bfir_out_if import bfir_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          run_last;

  modport source (output valid, sample_out, run_last, input ready);
  modport sink   (input valid, sample_out, run_last, output ready);
endinterface

[design/bfir_mac.sv]
// bfir_mac: shared multiply-accumulate pipeline (tap forming, multiply, add).
// Depends on bfir_pkg; fed one tap per cycle by block_fir_filter.

module bfir_mac import bfir_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  mac_ctl_t                    ctl_i,
  input  logic signed [COEF_BITS-1:0] coef_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  output logic                        busy_o,
  output logic signed [ACC_BITS-1:0]  acc_o
);

  logic signed [H_BITS-1:0]      coef_ext;
  logic signed [H_BITS-1:0]      one_c;
  logic signed [H_BITS-1:0]      h_d, h_q;
  logic signed [SAMPLE_BITS-1:0] x_d, x_q;
  logic signed [PROD_BITS-1:0]   prod_d, prod_q;
  logic signed [ACC_BITS-1:0]    acc_q;
  logic                          s2_vld_q, s3_vld_q;

  // high-pass: negate every tap, add 1.0 at the centre tap
  always_comb begin
    coef_ext = H_BITS'(coef_i);
    one_c    = ctl_i.centre ? H_ONE : '0;
    h_d      = ctl_i.highpass ? (one_c - coef_ext) : coef_ext;
    x_d      = ctl_i.smp_vld ? smp_i : '0;
  end

  assign prod_d = PROD_BITS'(h_q) * PROD_BITS'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= ctl_i.vld;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    x_q    <= x_d;
    prod_q <= prod_d;
    if (clr_i) begin
      acc_q <= '0;
    end else if (s3_vld_q) begin
      acc_q <= acc_q + ACC_BITS'(prod_q);
    end
  end

  assign busy_o = s2_vld_q | s3_vld_q;
  assign acc_o  = acc_q;

endmodule

[design/block_fir_filter.sv]
// block_fir_filter: block-wise direct-form FIR with tail flush and high-pass mode.
// Depends on bfir_pkg, bfir_in_if / bfir_out_if and bfir_mac.
//
//   channel   dir  transfer when        carries
//   in_i      in   valid & ready        action, sample_in, coef_index, coef_value, block_end
//   out_o     out  valid & ready        sample_out, run_last
//   cfg       in   cfg_we_i             cfg_idx_i, cfg_wdata_i (tap_count, highpass_mode)
//
// A coefficient load leaves the block idle. For a sample, and again for each tail
// result of a block end, one MAC walks the taps in use, one per cycle, followed
// by a three-stage drain of the MAC pipeline.
// Input ready is high only while idle; the result register holds while out_o stalls,
// and a finished result waits for it before the next tail starts.
// Reset leaves the delay line empty (per-entry valid bits); coefficients need loading.

module block_fir_filter import bfir_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i,
  bfir_in_if.sink                 in_i,
  bfir_out_if.source              out_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic signed [ACC_BITS-1:0] SAT_MAX = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1 << (COEF_FRAC - 1));

  // configuration
  logic [TAP_BITS-1:0] tap_count_q;
  logic                highpass_q;
  logic [TAP_BITS-1:0] taps;
  logic [TAP_BITS-1:0] centre_idx;

  // sequencer
  logic [1:0]            state_q, state_d;
  logic [TAP_BITS-1:0]   tap_idx_q, tap_idx_d;
  logic [TAP_BITS-1:0]   tails_q, tails_d;
  logic                  blk_end_q, blk_end_d;
  logic [RING_AW-1:0]    wp_q, wp_d;
  logic [RING_DEPTH-1:0] ring_vld_q, ring_vld_d;
  logic                  in_acc, issue, ring_we, mac_clr, out_load;

  // memories and read stage
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
  logic signed [COEF_BITS-1:0]   rd_coef_q;
  logic signed [SAMPLE_BITS-1:0] rd_smp_q;
  logic [RING_AW-1:0]            rd_addr;
  mac_ctl_t                      rd_ctl_q;

  // MAC and result
  logic                          mac_busy;
  logic signed [ACC_BITS-1:0]    mac_acc;
  logic signed [ACC_BITS-1:0]    rnd, shr;
  logic signed [SAMPLE_BITS-1:0] res;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
      highpass_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAP_COUNT: tap_count_q <= cfg_wdata_i;
        CFG_HIGHPASS:  highpass_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tap_count_q == '0) begin
      taps = TAP_BITS'(1);
    end else if (tap_count_q > TAP_BITS'(MAX_TAPS)) begin
      taps = TAP_BITS'(MAX_TAPS);
    end else begin
      taps = tap_count_q;
    end
    centre_idx = (taps - TAP_BITS'(1)) >> 1;
  end

  assign in_acc      = in_i.valid & in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign rd_addr     = wp_q - tap_idx_q[RING_AW-1:0];

  always_comb begin
    state_d     = state_q;
    tap_idx_d   = tap_idx_q;
    tails_d     = tails_q;
    blk_end_d   = blk_end_q;
    wp_d        = wp_q;
    ring_vld_d  = ring_vld_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    issue       = 1'b0;
    ring_we     = 1'b0;
    mac_clr     = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.action == ACT_FILTER) begin
          wp_d             = wp_q + RING_AW'(1);
          ring_we          = 1'b1;
          ring_vld_d[wp_d] = 1'b1;
          tap_idx_d        = '0;
          tails_d          = in_i.block_end ? (taps - TAP_BITS'(1)) : '0;
          blk_end_d        = in_i.block_end;
          mac_clr          = 1'b1;
          state_d          = S_RUN;
        end
      end
      S_RUN: begin
        issue     = 1'b1;
        tap_idx_d = tap_idx_q + TAP_BITS'(1);
        if (tap_idx_q == taps - TAP_BITS'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_ctl_q.vld && !mac_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (tails_q != '0) begin
            // tail output: shift a zero in
            tails_d          = tails_q - TAP_BITS'(1);
            wp_d             = wp_q + RING_AW'(1);
            ring_vld_d[wp_d] = 1'b0;
            tap_idx_d        = '0;
            mac_clr          = 1'b1;
            state_d          = S_RUN;
          end else begin
            if (blk_end_q) begin
              ring_vld_d = '0;
            end
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_idx_q   <= '0;
      tails_q     <= '0;
      blk_end_q   <= 1'b0;
      wp_q        <= '0;
      ring_vld_q  <= '0;
      out_valid_q <= 1'b0;
      rd_ctl_q    <= '0;
    end else begin
      state_q           <= state_d;
      tap_idx_q         <= tap_idx_d;
      tails_q           <= tails_d;
      blk_end_q         <= blk_end_d;
      wp_q              <= wp_d;
      ring_vld_q        <= ring_vld_d;
      out_valid_q       <= out_valid_d;
      rd_ctl_q.vld      <= issue;
      rd_ctl_q.centre   <= (tap_idx_q == centre_idx);
      rd_ctl_q.highpass <= highpass_q;
      rd_ctl_q.smp_vld  <= ring_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.action == ACT_LOAD && in_i.coef_index < TAP_BITS'(MAX_TAPS)) begin
      coef_mem[in_i.coef_index[COEF_AW-1:0]] <= in_i.coef_value;
    end
    if (issue) begin
      rd_coef_q <= coef_mem[tap_idx_q[COEF_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_d] <= in_i.sample_in;
    end
    if (issue) begin
      rd_smp_q <= ring_mem[rd_addr];
    end
  end

  bfir_mac u_bfir_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (mac_clr),
    .ctl_i  (rd_ctl_q),
    .coef_i (rd_coef_q),
    .smp_i  (rd_smp_q),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  // round half up to Q1.15, then saturate
  always_comb begin
    rnd = mac_acc + RND_HALF;
    shr = rnd >>> COEF_FRAC;
    if (shr > SAT_MAX) begin
      res = SAMPLE_BITS'(SAT_MAX);
    end else if (shr < SAT_MIN) begin
      res = SAMPLE_BITS'(SAT_MIN);
    end else begin
      res = SAMPLE_BITS'(shr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= res;
      out_last_q   <= blk_end_q & (tails_q == '0);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.run_last   = out_last_q;

endmodule

[design/bfir_chk.sv]
// bfir_chk: port-level checks on block_fir_filter, attached by bind.
// Depends on bfir_pkg and the channel interfaces.

module bfir_chk import bfir_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  bfir_in_if.sink    in_i,
  bfir_out_if.source out_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_o.sample_out) && $stable(out_o.run_last))
    else $error("result changed while stalled");

  // a coefficient load finishes in its own cycle
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.action == ACT_LOAD |=> in_i.ready)
    else $error("busy after a coefficient load");

  // a sample keeps the block busy while the taps are walked
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.action == ACT_FILTER |=> !in_i.ready)
    else $error("ready straight after a sample transfer");

endmodule

bind block_fir_filter bfir_chk u_bfir_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
